// File: rtl/core/gpn_pkg.sv
`timescale 1ns / 1ps

package gpn_pkg;

   // Hat angle limits in hundredths of a degree; the all-ones code means centered.
   localparam logic [15:0] HAT_CENTER    = 16'hFFFF;
   localparam logic [15:0] HAT_UP_RIGHT  = 16'd4500;
   localparam logic [15:0] HAT_RIGHT_DN  = 16'd13500;
   localparam logic [15:0] HAT_DN_LEFT   = 16'd22500;
   localparam logic [15:0] HAT_LEFT_UP   = 16'd31500;

   // Full-scale trigger value and the top of the raw axis range.
   localparam logic [7:0]  TRIG_FULL     = 8'd255;
   localparam logic [15:0] AXIS_TOP      = 16'hFFFF;

   // Saturation limits of a centered stick value.
   localparam logic [15:0] STICK_MAX     = 16'h7FFF;
   localparam logic [15:0] STICK_MIN     = 16'h8000;

   // Raw button positions.
   localparam int BTN_SQUARE   = 0;
   localparam int BTN_CROSS    = 1;
   localparam int BTN_CIRCLE   = 2;
   localparam int BTN_TRIANGLE = 3;
   localparam int BTN_LB       = 4;
   localparam int BTN_RB       = 5;
   localparam int BTN_LT       = 6;
   localparam int BTN_RT       = 7;
   localparam int BTN_SHARE    = 8;
   localparam int BTN_OPTIONS  = 9;
   localparam int BTN_L3       = 10;
   localparam int BTN_R3       = 11;

   // Pad word bit positions.
   localparam int PAD_UP    = 0;
   localparam int PAD_DOWN  = 1;
   localparam int PAD_LEFT  = 2;
   localparam int PAD_RIGHT = 3;
   localparam int PAD_START = 4;
   localparam int PAD_BACK  = 5;
   localparam int PAD_L3    = 6;
   localparam int PAD_R3    = 7;
   localparam int PAD_LB    = 8;
   localparam int PAD_RB    = 9;
   localparam int PAD_A     = 12;
   localparam int PAD_B     = 13;
   localparam int PAD_X     = 14;
   localparam int PAD_Y     = 15;

   typedef struct packed {
      logic [11:0] raw_buttons;
      logic [15:0] axis_x;
      logic [15:0] axis_y;
      logic [15:0] axis_z;
      logic [15:0] axis_rot_x;
      logic [15:0] axis_rot_y;
      logic [15:0] axis_rot_z;
      logic [15:0] hat_angle;
   } req_type;

   typedef struct packed {
      logic [15:0]        pad_buttons;
      logic [7:0]         left_trigger;
      logic [7:0]         right_trigger;
      logic signed [15:0] left_stick_x;
      logic signed [15:0] left_stick_y;
      logic signed [15:0] right_stick_x;
      logic signed [15:0] right_stick_y;
   } rsp_type;

   // Raw value minus rest, saturated to the signed 16-bit range.
   function automatic logic [15:0] center_axis(input logic [15:0] value,
                                               input logic [15:0] rest);
      logic [16:0] diff;
      logic [15:0] result;
      begin
         diff = {1'b0, value} - {1'b0, rest};
         if (diff[16] != diff[15]) begin
            result = diff[16] ? STICK_MIN : STICK_MAX;
         end else begin
            result = diff[15:0];
         end
         return result;
      end
   endfunction

   // Remaps the raw buttons and decodes the hat into direction bits.
   function automatic logic [15:0] map_buttons(input logic [11:0] btn,
                                               input logic [15:0] hat);
      logic [15:0] pad;
      begin
         pad            = '0;
         pad[PAD_X]     = btn[BTN_SQUARE];
         pad[PAD_A]     = btn[BTN_CROSS];
         pad[PAD_B]     = btn[BTN_CIRCLE];
         pad[PAD_Y]     = btn[BTN_TRIANGLE];
         pad[PAD_LB]    = btn[BTN_LB];
         pad[PAD_RB]    = btn[BTN_RB];
         pad[PAD_BACK]  = btn[BTN_SHARE];
         pad[PAD_START] = btn[BTN_OPTIONS];
         pad[PAD_L3]    = btn[BTN_L3];
         pad[PAD_R3]    = btn[BTN_R3];
         if (hat != HAT_CENTER) begin
            pad[PAD_UP]    = (hat <= HAT_UP_RIGHT) || (hat >= HAT_LEFT_UP);
            pad[PAD_RIGHT] = (hat >= HAT_UP_RIGHT) && (hat <= HAT_RIGHT_DN);
            pad[PAD_DOWN]  = (hat >= HAT_RIGHT_DN) && (hat <= HAT_DN_LEFT);
            pad[PAD_LEFT]  = (hat >= HAT_DN_LEFT) && (hat <= HAT_LEFT_UP);
         end
         return pad;
      end
   endfunction

endpackage

// File: rtl/core/gamepad_report_normalizer_core.sv
`timescale 1ns / 1ps

// Normalizes one raw joystick report into a standard pad word, two 8-bit
// triggers and four signed stick values. The first report accepted after
// reset also latches the six axis rest levels, so its sticks read zero. A
// report goes from acceptance to the result register through, for each
// trigger, a setup step and eight steps of a shared bit-serial restoring
// divider that produces one quotient bit per cycle, then an assembly step
// that loads the result. The assembly step waits while an earlier result is
// still held in the output register. The next report is accepted as soon as
// the previous one has reached the output register, even while that result
// still waits for its transfer.
module gamepad_report_normalizer_core
   import gpn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // Control state.
   state_type   state_ff, state_in;
   logic        captured_ff, captured_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        sel_ff, sel_in;
   logic [2:0]  cnt_ff, cnt_in;

   // Payload and datapath registers.
   req_type     req_ff, req_in;
   logic [15:0] rest_ff [6];
   logic [15:0] rest_in [6];
   logic [15:0] rem_ff, rem_in;
   logic [7:0]  quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [7:0]  lt_ff, lt_in;
   logic [7:0]  rt_ff, rt_in;
   rsp_type     rsp_ff, rsp_in;

   // Trigger setup and divider step signals.
   logic [15:0] trig_val;
   logic [15:0] trig_rest;
   logic [15:0] trig_dist;
   logic [15:0] trig_span;
   logic [23:0] trig_num;
   logic [16:0] div_shift;
   logic        div_ge;
   logic        req_xfer;
   logic        out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Distance from rest and span on that side for the selected trigger.
   always_comb begin
      trig_val  = sel_ff ? req_ff.axis_rot_z : req_ff.axis_z;
      trig_rest = sel_ff ? rest_ff[5] : rest_ff[2];
      if (trig_val >= trig_rest) begin
         trig_dist = trig_val - trig_rest;
         trig_span = (trig_rest != AXIS_TOP) ? (AXIS_TOP - trig_rest) : 16'd1;
      end else begin
         trig_dist = trig_rest - trig_val;
         trig_span = trig_rest;
      end
      // Distance times 255 as a shift and a subtract.
      trig_num = {trig_dist, 8'h00} - {8'h00, trig_dist};
   end

   // One restoring division step: shift in the next dividend bit, try the divisor.
   always_comb begin
      div_shift = {rem_ff, quo_ff[7]};
      div_ge    = (div_shift >= {1'b0, dvs_ff});
   end

   // Next-state and datapath logic.
   always_comb begin
      state_in     = state_ff;
      captured_in  = captured_ff;
      rsp_valid_in = rsp_valid_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      rest_in      = rest_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      lt_in        = lt_ff;
      rt_in        = rt_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               req_in = req_data;
               sel_in = 1'b0;
               // The first report sets the rest levels.
               if (!captured_ff) begin
                  captured_in = 1'b1;
                  rest_in[0]  = req_data.axis_x;
                  rest_in[1]  = req_data.axis_y;
                  rest_in[2]  = req_data.axis_z;
                  rest_in[3]  = req_data.axis_rot_x;
                  rest_in[4]  = req_data.axis_rot_y;
                  rest_in[5]  = req_data.axis_rot_z;
               end
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // The quotient fits in eight bits, so the upper part starts below the divisor.
            rem_in   = trig_num[23:8];
            quo_in   = trig_num[7:0];
            dvs_in   = trig_span;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_ge ? 16'(div_shift - {1'b0, dvs_ff}) : div_shift[15:0];
            quo_in = {quo_ff[6:0], div_ge};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               if (sel_ff) begin
                  rt_in    = {quo_ff[6:0], div_ge};
                  state_in = ST_DONE;
               end else begin
                  lt_in    = {quo_ff[6:0], div_ge};
                  sel_in   = 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_DONE: begin
            // Load the result once the output register is free.
            if (out_free) begin
               rsp_in.pad_buttons   = map_buttons(req_ff.raw_buttons, req_ff.hat_angle);
               rsp_in.left_trigger  = req_ff.raw_buttons[BTN_LT] ? TRIG_FULL : lt_ff;
               rsp_in.right_trigger = req_ff.raw_buttons[BTN_RT] ? TRIG_FULL : rt_ff;
               rsp_in.left_stick_x  = center_axis(req_ff.axis_x, rest_ff[0]);
               rsp_in.left_stick_y  = center_axis(req_ff.axis_y, rest_ff[1]);
               rsp_in.right_stick_x = center_axis(req_ff.axis_rot_x, rest_ff[3]);
               rsp_in.right_stick_y = center_axis(req_ff.axis_rot_y, rest_ff[4]);
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         captured_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         captured_ff  <= captured_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rest_ff <= rest_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      lt_ff   <= lt_in;
      rt_ff   <= rt_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// File: test/tb_gamepad_report_normalizer_core.sv
`timescale 1ns / 1ps

module tb_gamepad_report_normalizer_core;
   import gpn_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 300;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Idle and stall rates in percent; a forced output hold is requested by
   // bumping the request count and is counted down in the receiver process.
   int gap_pct       = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_started = 0;
   int hold_left     = 0;

   int error_count = 0;
   int idle_cycles = 0;

   // Predictor state: rest levels in the order x, y, z, rot_x, rot_y, rot_z.
   logic [15:0] rest_axis [6];
   logic        rests_latched = 1'b0;
   rsp_type     pending_pad_reports [$];

   // Pad bit driven by each raw button; the analog trigger buttons drive none.
   int pad_bit_of [12] = '{PAD_X, PAD_A, PAD_B, PAD_Y, PAD_LB, PAD_RB, -1, -1,
                           PAD_BACK, PAD_START, PAD_L3, PAD_R3};

   // Hat angles where the decoded direction changes, plus the end of the circle.
   logic [15:0] hat_marks [5] = '{HAT_UP_RIGHT, HAT_RIGHT_DN, HAT_DN_LEFT,
                                  HAT_LEFT_UP, 16'd36000};

   gamepad_report_normalizer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Trigger distance from rest, scaled by the span on that side of rest.
   function automatic logic [7:0] scale_trigger_level(logic [15:0] value,
                                                      logic [15:0] rest);
      int unsigned v;
      int unsigned r;
      int unsigned span;
      v = value;
      r = rest;
      if (v >= r) begin
         span = (r == 32'd65535) ? 1 : 65535 - r;
         return 8'(((v - r) * 255) / span);
      end
      return 8'(((r - v) * 255) / r);
   endfunction

   // Stick position relative to rest, clamped to the signed 16-bit range.
   function automatic logic [15:0] stick_offset(logic [15:0] value, logic [15:0] rest);
      int d;
      d = int'(value) - int'(rest);
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      return d[15:0];
   endfunction

   // Expected pad report for one accepted raw report; latches rests on the first.
   function automatic rsp_type predict_pad_report(req_type r);
      logic [15:0] ax [6];
      logic [15:0] pad;
      rsp_type     o;
      ax = '{r.axis_x, r.axis_y, r.axis_z, r.axis_rot_x, r.axis_rot_y, r.axis_rot_z};
      if (!rests_latched) begin
         rest_axis     = ax;
         rests_latched = 1'b1;
      end
      pad = '0;
      for (int i = 0; i < 12; i++) begin
         if (r.raw_buttons[i] && pad_bit_of[i] >= 0) pad[pad_bit_of[i]] = 1'b1;
      end
      if (r.hat_angle != HAT_CENTER) begin
         if (r.hat_angle <= HAT_UP_RIGHT || r.hat_angle >= HAT_LEFT_UP) pad[PAD_UP] = 1'b1;
         if (r.hat_angle >= HAT_UP_RIGHT && r.hat_angle <= HAT_RIGHT_DN)
            pad[PAD_RIGHT] = 1'b1;
         if (r.hat_angle >= HAT_RIGHT_DN && r.hat_angle <= HAT_DN_LEFT)
            pad[PAD_DOWN] = 1'b1;
         if (r.hat_angle >= HAT_DN_LEFT && r.hat_angle <= HAT_LEFT_UP)
            pad[PAD_LEFT] = 1'b1;
      end
      o.pad_buttons   = pad;
      o.left_trigger  = r.raw_buttons[BTN_LT] ? TRIG_FULL :
                        scale_trigger_level(ax[2], rest_axis[2]);
      o.right_trigger = r.raw_buttons[BTN_RT] ? TRIG_FULL :
                        scale_trigger_level(ax[5], rest_axis[5]);
      o.left_stick_x  = stick_offset(ax[0], rest_axis[0]);
      o.left_stick_y  = stick_offset(ax[1], rest_axis[1]);
      o.right_stick_x = stick_offset(ax[3], rest_axis[3]);
      o.right_stick_y = stick_offset(ax[4], rest_axis[4]);
      return o;
   endfunction

   function automatic req_type make_report(logic [11:0] btn, logic [15:0] x,
                                           logic [15:0] y, logic [15:0] z,
                                           logic [15:0] rx, logic [15:0] ry,
                                           logic [15:0] rz, logic [15:0] hat);
      req_type r;
      r.raw_buttons = btn;
      r.axis_x      = x;
      r.axis_y      = y;
      r.axis_z      = z;
      r.axis_rot_x  = rx;
      r.axis_rot_y  = ry;
      r.axis_rot_z  = rz;
      r.hat_angle   = hat;
      return r;
   endfunction

   function automatic req_type report_at_rest(logic [11:0] btn, logic [15:0] hat);
      return make_report(btn, rest_axis[0], rest_axis[1], rest_axis[2],
                         rest_axis[3], rest_axis[4], rest_axis[5], hat);
   endfunction

   // Axis values lean toward the ends of the range and the region around rest.
   function automatic logic [15:0] pick_axis(logic [15:0] rest);
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return AXIS_TOP;
         2: return rest;
         3: return rest + 16'd1;
         4: return rest - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // Hat angles lean toward centered, the direction boundaries and values past the circle.
   function automatic logic [15:0] pick_hat();
      case ($urandom_range(5))
         0: return HAT_CENTER;
         1: return hat_marks[$urandom_range(4)] + 16'($urandom_range(2)) - 16'd1;
         2: return 16'($urandom_range(65535, 36000));
         default: return 16'($urandom_range(36000));
      endcase
   endfunction

   function automatic req_type random_report();
      return make_report(12'($urandom), pick_axis(rest_axis[0]), pick_axis(rest_axis[1]),
                         pick_axis(rest_axis[2]), pick_axis(rest_axis[3]),
                         pick_axis(rest_axis[4]), pick_axis(rest_axis[5]), pick_hat());
   endfunction

   task automatic report_error(string what, int got, int want);
      $display("ERROR at %0t: %s is %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_field(string what, int got, int want);
      if (got != want) report_error(what, got, want);
   endtask

   // Sends one report; called and returning just after a rising edge.
   // Valid stays high across back-to-back transfers.
   task automatic send_report(req_type r);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pending_pad_reports = {pending_pad_reports, predict_pad_report(r)};
   endtask

   // The first report latches the rest levels, including the left trigger rest at
   // the top of the range and sticks placed so both clamps can be reached.
   task automatic test_rest_capture();
      logic [11:0] btn;
      btn = '0;
      btn[BTN_LT]     = 1'b1;
      btn[BTN_SQUARE] = 1'b1;
      send_report(make_report(btn, 16'h0000, AXIS_TOP, AXIS_TOP, 16'h8000, 16'h7FFF,
                              16'($urandom_range(65534, 1)), HAT_CENTER));
   endtask

   // Every raw button, two at a time, with all axes at rest.
   task automatic test_button_map();
      for (int i = 0; i < 6; i++) begin
         send_report(report_at_rest(12'((1 << i) | (1 << (i + 6))), HAT_CENTER));
      end
   endtask

   task automatic test_hat_boundaries();
      logic [15:0] angles [9];
      angles = '{16'd0, 16'd4499, HAT_UP_RIGHT, HAT_RIGHT_DN, HAT_DN_LEFT, HAT_LEFT_UP,
                 16'd36000, 16'd36001, 16'hFFFE};
      foreach (angles[i]) send_report(report_at_rest(12'h000, angles[i]));
   endtask

   // Stick clamps on both sides, exact limits, and triggers at both ends.
   task automatic test_axis_extremes();
      send_report(make_report(12'h000, AXIS_TOP, 16'h0000, 16'h0000, 16'h0000, AXIS_TOP,
                              16'h0000, HAT_CENTER));
      send_report(make_report(12'h000, 16'h7FFF, 16'h7FFF, 16'hFFFE, AXIS_TOP, 16'h0000,
                              AXIS_TOP, HAT_CENTER));
      send_report(make_report(12'h000, 16'h8000, 16'h8000, AXIS_TOP, 16'h7FFF, 16'h8000,
                              rest_axis[5] + 16'd1, HAT_CENTER));
   endtask

   task automatic test_random_traffic(int gap, int stall, int count);
      gap_pct   = gap;
      stall_pct = stall;
      repeat (count) send_report(random_report());
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_output_backpressure();
      gap_pct   = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (20) send_report(random_report());
   endtask

   // Receiver ready: random stalls, or a forced hold counted down here.
   always @(posedge clock) begin
      if (holds_started != hold_requests) begin
         holds_started <= hold_requests;
         hold_left     <= HOLD_CYCLES - 1;
         rsp_ready     <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Each result transfer is compared with the oldest expected report.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pad_reports.size() == 0) begin
            report_error("unexpected result, pad_buttons", rsp_data.pad_buttons, -1);
         end else begin
            want = pending_pad_reports.pop_front();
            check_field("pad_buttons", rsp_data.pad_buttons, want.pad_buttons);
            check_field("left_trigger", rsp_data.left_trigger, want.left_trigger);
            check_field("right_trigger", rsp_data.right_trigger, want.right_trigger);
            check_field("left_stick_x", rsp_data.left_stick_x, want.left_stick_x);
            check_field("left_stick_y", rsp_data.left_stick_y, want.left_stick_y);
            check_field("right_stick_x", rsp_data.right_stick_x, want.right_stick_x);
            check_field("right_stick_y", rsp_data.right_stick_y, want.right_stick_y);
         end
      end
   end

   // Ends the run when no transfer happens on either side for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_rest_capture();
      test_button_map();
      test_hat_boundaries();
      test_axis_extremes();
      test_random_traffic(0, 0, 225);
      test_random_traffic(49, 0, 225);
      test_random_traffic(0, 49, 225);
      test_output_backpressure();
      test_random_traffic(30, 30, 225);

      // Drain: wait for every expected report, then allow a late extra one.
      req_valid <= 1'b0;
      while (pending_pad_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/gpn_pkg.sv
rtl/core/gamepad_report_normalizer_core.sv
test/tb_gamepad_report_normalizer_core.sv
